>>> rtl/att_pkg.sv
`default_nettype none
package att_pkg;

  // Default table size and report limit
  localparam int SLOT_COUNT_DEF = 32;
  localparam int MAX_REPORTS    = 32;

  // Register reset values and byte-address decode width
  localparam logic [31:0] LIFETIME_RST    = 32'd60000;
  localparam logic [31:0] IDENT_HOLD_RST  = 32'd18000;
  localparam logic [31:0] ALERT_HOLD_RST  = 32'd60000;
  localparam int          PADDR_W         = 4;

  typedef enum logic [1:0] {
    REG_LIFETIME   = 2'd0,
    REG_IDENT_HOLD = 2'd1,
    REG_ALERT_HOLD = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    FN_FIND_CREATE = 3'd0,
    FN_FIND        = 3'd1,
    FN_FLIGHT_STAT = 3'd2,
    FN_SURV_STAT   = 3'd3,
    FN_TELEMETRY   = 3'd4,
    FN_SWEEP       = 3'd5,
    FN_CLEAR       = 3'd6,
    FN_UNDEF       = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    OC_DONE      = 3'd0,
    OC_CREATED   = 3'd1,
    OC_MISSING   = 3'd2,
    OC_ADDR_ZERO = 3'd3,
    OC_REPORT    = 3'd4,
    OC_SWEEP_END = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [23:0] address;
    logic [4:0]  slot_sel;
    logic [2:0]  status_code;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [4:0]  slot_out;
    logic [23:0] address_out;
    logic        emergency_on;
    logic        ident_on;
    logic [5:0]  report_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] track_lifetime_ms;
    logic [31:0] ident_hold_ms;
    logic [31:0] alert_hold_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_FIND,
    ST_FIND_END,
    ST_SWEEP,
    ST_SWEEP_END
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SINGLE,
    OP_FIND,
    OP_FIND_END,
    OP_SWEEP,
    OP_SWEEP_END
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   idx_inc;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/att_cfg.sv
`default_nettype none
module att_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [att_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output att_pkg::cfg_t                       cfg
);
  import att_pkg::*;

  logic [1:0] ridx;

  assign ridx   = paddr[3:2];
  assign pready = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_lifetime_ms <= LIFETIME_RST;
      cfg.ident_hold_ms     <= IDENT_HOLD_RST;
      cfg.alert_hold_ms     <= ALERT_HOLD_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_LIFETIME:   cfg.track_lifetime_ms <= pwdata;
        REG_IDENT_HOLD: cfg.ident_hold_ms     <= pwdata;
        REG_ALERT_HOLD: cfg.alert_hold_ms     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (ridx)
      REG_LIFETIME:   prdata = cfg.track_lifetime_ms;
      REG_IDENT_HOLD: prdata = cfg.ident_hold_ms;
      REG_ALERT_HOLD: prdata = cfg.alert_hold_ms;
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/att_ctrl.sv
`default_nettype none
module att_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire att_pkg::in_item_t in_data,
  output logic                   in_ready,
  input  wire att_pkg::status_t  status,
  output att_pkg::cmd_t          cmd
);
  import att_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.idx_inc = 1'b0;
    cmd.op      = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_data.func inside {FN_FIND_CREATE, FN_FIND} && in_data.address != '0) begin
            state_next = ST_FIND;
          end else if (in_data.func == FN_SWEEP) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_SINGLE;
          end
        end
      end
      ST_SINGLE: begin
        if (status.out_free) begin
          cmd.op     = OP_SINGLE;
          state_next = ST_IDLE;
        end
      end
      // Hold the scan while a result waits, so a hit can always be emitted
      ST_FIND: begin
        if (status.out_free) begin
          cmd.op = OP_FIND;
          if (status.hit) begin
            state_next = ST_IDLE;
          end else if (status.idx_last) begin
            state_next = ST_FIND_END;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_FIND_END: begin
        if (status.out_free) begin
          cmd.op     = OP_FIND_END;
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (status.out_free) begin
          cmd.op = OP_SWEEP;
          if (status.idx_last) begin
            state_next = ST_SWEEP_END;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_SWEEP_END: begin
        if (status.out_free) begin
          cmd.op     = OP_SWEEP_END;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/att_dp.sv
`default_nettype none
module att_dp #(
  parameter int SLOT_COUNT = att_pkg::SLOT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire att_pkg::cmd_t      cmd,
  output att_pkg::status_t        status,
  input  wire att_pkg::in_item_t  in_data,
  input  wire att_pkg::cfg_t      cfg,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output att_pkg::out_item_t      out_data
);
  import att_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);

  in_item_t            item;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       empty_idx;
  logic                have_empty;
  logic [5:0]          n_rep;

  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] changed;
  logic [SLOT_COUNT-1:0] tel;
  logic [23:0]           key_mem   [SLOT_COUNT];
  logic [31:0]           touch_mem [SLOT_COUNT];
  logic [31:0]           ident_mem [SLOT_COUNT];
  logic [31:0]           alert_mem [SLOT_COUNT];

  logic [IW-1:0] sel_idx;
  logic          sel_bad;
  logic          now_ok;
  logic          hit;
  logic          drop;
  logic          ie;
  logic          ae;
  logic          chg_new;
  logic          rep;
  logic [31:0]   ident_new;
  logic [31:0]   alert_new;
  logic          st_alert;
  logic          st_ident;
  logic          emit;
  out_item_t     res;

  assign sel_idx = IW'(item.slot_sel);
  assign sel_bad = 32'(item.slot_sel) >= 32'(SLOT_COUNT);
  assign now_ok  = item.now_ms != '0;
  assign hit     = valid[idx] && key_mem[idx] == item.address;

  // Ageing checks on the scanned slot
  assign drop      = now_ok && cfg.track_lifetime_ms < (item.now_ms - touch_mem[idx]);
  assign ie        = ident_mem[idx] != '0 && now_ok &&
                     cfg.ident_hold_ms < (item.now_ms - ident_mem[idx]);
  assign ae        = alert_mem[idx] != '0 && now_ok &&
                     cfg.alert_hold_ms < (item.now_ms - alert_mem[idx]);
  assign ident_new = ie ? '0 : ident_mem[idx];
  assign alert_new = ae ? '0 : alert_mem[idx];
  assign chg_new   = changed[idx] | ie | ae;
  assign rep       = valid[idx] && !drop && chg_new && tel[idx] && !n_rep[5];

  assign status.hit      = hit;
  assign status.idx_last = idx == IW'(SLOT_COUNT - 1);
  assign status.out_free = !out_valid || out_ready;

  // Decode status codes into stamps
  always_comb begin
    st_alert = 1'b0;
    st_ident = 1'b0;
    case (item.func)
      FN_FLIGHT_STAT: begin
        st_alert = item.status_code inside {3'd2, 3'd3, 3'd4};
        st_ident = item.status_code inside {3'd4, 3'd5};
      end
      FN_SURV_STAT: begin
        st_alert = item.status_code inside {3'd1, 3'd2};
        st_ident = item.status_code == 3'd3;
      end
      default: ;
    endcase
  end

  // Build the result for this cycle
  always_comb begin
    emit = 1'b0;
    res  = '0;
    res.last = 1'b1;
    case (cmd.op)
      OP_SINGLE: begin
        emit = 1'b1;
        case (item.func)
          FN_FIND_CREATE, FN_FIND: res.outcome = OC_ADDR_ZERO;
          FN_FLIGHT_STAT, FN_SURV_STAT, FN_TELEMETRY: begin
            res.outcome  = sel_bad ? OC_MISSING : OC_DONE;
            res.slot_out = item.slot_sel;
          end
          FN_CLEAR: res.outcome = OC_DONE;
          default:  res.outcome = OC_MISSING;
        endcase
      end
      OP_FIND: begin
        emit            = hit;
        res.outcome     = OC_DONE;
        res.slot_out    = 5'(idx);
        res.address_out = item.address;
      end
      OP_FIND_END: begin
        emit = 1'b1;
        if (item.func == FN_FIND || !have_empty) begin
          res.outcome = OC_MISSING;
        end else begin
          res.outcome     = OC_CREATED;
          res.slot_out    = 5'(empty_idx);
          res.address_out = item.address;
        end
      end
      OP_SWEEP: begin
        emit             = rep;
        res.outcome      = OC_REPORT;
        res.slot_out     = 5'(idx);
        res.address_out  = key_mem[idx];
        res.emergency_on = alert_new != '0;
        res.ident_on     = ident_new != '0;
        res.last         = 1'b0;
      end
      OP_SWEEP_END: begin
        emit             = 1'b1;
        res.outcome      = OC_SWEEP_END;
        res.report_count = n_rep;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

  // Item latch and scan counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item       <= in_data;
      idx        <= '0;
      have_empty <= 1'b0;
      n_rep      <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.op == OP_FIND && !valid[idx] && !have_empty) begin
        have_empty <= 1'b1;
        empty_idx  <= idx;
      end
      if (cmd.op == OP_SWEEP && rep) begin
        n_rep <= n_rep + 1'b1;
      end
    end
  end

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      case (cmd.op)
        OP_SINGLE: begin
          if (item.func == FN_CLEAR) begin
            valid <= '0;
          end
        end
        OP_FIND_END: begin
          if (item.func == FN_FIND_CREATE && have_empty) begin
            valid[empty_idx] <= 1'b1;
          end
        end
        OP_SWEEP: begin
          if (valid[idx] && drop) begin
            valid[idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Slot entries
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SINGLE: begin
        if (!sel_bad) begin
          if (item.func == FN_TELEMETRY) begin
            tel[sel_idx] <= 1'b1;
          end
          if (st_alert) begin
            alert_mem[sel_idx] <= item.now_ms;
          end
          if (st_ident) begin
            ident_mem[sel_idx] <= item.now_ms;
          end
          // Mark and touch the slot once for any stamp or telemetry
          if (item.func == FN_TELEMETRY || st_alert || st_ident) begin
            changed[sel_idx]   <= 1'b1;
            touch_mem[sel_idx] <= item.now_ms;
          end
        end
      end
      OP_FIND: begin
        if (hit) begin
          touch_mem[idx] <= item.now_ms;
        end
      end
      OP_FIND_END: begin
        if (item.func == FN_FIND_CREATE && have_empty) begin
          key_mem[empty_idx]   <= item.address;
          changed[empty_idx]   <= 1'b0;
          tel[empty_idx]       <= 1'b0;
          touch_mem[empty_idx] <= item.now_ms;
          alert_mem[empty_idx] <= '0;
          ident_mem[empty_idx] <= '0;
        end
      end
      OP_SWEEP: begin
        if (valid[idx] && !drop) begin
          ident_mem[idx] <= ident_new;
          alert_mem[idx] <= alert_new;
          changed[idx]   <= chg_new && !rep;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/aircraft_track_table.sv
`default_nettype none
// Channel  Signals                              Direction
// input    in_valid / in_ready / in_data        item in
// output   out_valid / out_ready / out_data     item out
// config   psel penable pwrite paddr pwdata     register write and read
//
// Finds and sweeps scan one slot per cycle while the output is free, using
// the single slot read port of the datapath. Other operations emit one result.
// One item is in work at a time; the next is taken while a result waits.
// A stalled output holds the scan in place. Synchronous reset empties the table.
module aircraft_track_table #(
  parameter int SLOT_COUNT = att_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire att_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output att_pkg::out_item_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [att_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import att_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  att_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  att_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(in_data),
    .in_ready(in_ready), .status(status), .cmd(cmd)
  );

  att_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_data),
    .cfg(cfg), .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire
